// ===== rtl/csla_pkg.sv =====
// Shared constants for the carrier scan level averager.
// No dependencies; imported by carrier_scan_level_averager.
`timescale 1ns / 1ps

package csla_pkg;

	// Fixed field widths.
	localparam int CH_W    = 7;
	localparam int LVL_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int SPC_W   = 8;
	localparam int CPT_W   = 6;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 8;

	// Hit percentage dividend is hits * 100, at most 255 * 100.
	localparam int DVD_W     = 15;
	localparam int DIV_CNT_W = 4;
	localparam logic [DVD_W-1:0] PERCENT = 15'd100;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_SPC    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_CPT    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_STREAM = 2'd2;

	// Packet header bytes, in the order they go out.
	localparam logic [1:0] HDR_VERSION = 2'd0;
	localparam logic [1:0] HDR_CURSOR  = 2'd1;
	localparam logic [1:0] HDR_START   = 2'd2;
	localparam logic [1:0] HDR_COUNT   = 2'd3;

	localparam logic [BYTE_W-1:0] PKT_VERSION = 8'h01;

	// Result kinds.
	localparam logic KIND_TUNE = 1'b0;
	localparam logic KIND_PKT  = 1'b1;

	typedef logic [2:0] state_t;

endpackage

// ===== rtl/carrier_scan_level_averager.sv =====
// Carrier scan level averager: sequencer, hit-rate divider and level memory.
// Depends on csla_pkg.
`timescale 1ns / 1ps

// Usage.
// Each request on the input channel (in_valid/in_ready, field detect) is one
// carrier-detect sample for the channel that was last tuned. Each request
// produces one or more results on the output channel (out_valid/out_ready):
// optionally a level packet of byte results (kind 1), then always one tune
// result (kind 0) naming the channel to sample next, with last_item set.
// A sample that does not end a channel visit goes from acceptance straight
// to the tune result. A sample that ends a visit runs the hit percentage
// through a radix-2 divider of 15 steps and a read-modify-write of the level
// memory. If the tick ends with streaming on, the packet adds four header
// bytes and one level byte per channel in the tick, and every level is a
// separate read through the single read port of the level memory.
// One request is processed at a time; the next is taken once the tune
// result has been loaded into the output register, even while it waits.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the cursor and counters, returns the configuration to its
// defaults (one sample per visit, eight channels per tick, streaming off),
// and clears the per-entry valid flags so that every level reads as zero;
// there is no clearing pass and a request can be taken in the first cycle
// after reset. Configuration writes take effect at once; the user must make
// them only while idle, as the block itself does not enforce this.

module carrier_scan_level_averager
	import csla_pkg::*;
#(
	parameter int NUM_CHANNELS = 126,
	parameter int MAX_CHUNK    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CDATA_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               detect,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [CH_W-1:0]    channel,
	output logic [BYTE_W-1:0]  data_byte,
	output logic               last_item
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int LW = $clog2(MAX_CHUNK + 1);

	localparam state_t S_IDLE = 3'd0;
	localparam state_t S_DIV  = 3'd1;
	localparam state_t S_UPD  = 3'd2;
	localparam state_t S_HDR  = 3'd3;
	localparam state_t S_RD   = 3'd4;
	localparam state_t S_LV   = 3'd5;
	localparam state_t S_TUNE = 3'd6;

	// Configuration registers.
	logic [SPC_W-1:0] spc_q;
	logic [CPT_W-1:0] cpt_cfg_q;
	logic             stream_q;

	// Scan state.
	state_t           state_q;
	logic [CH_W-1:0]  cursor_q;
	logic [CH_W-1:0]  tick_start_q;
	logic [SPC_W-1:0] sample_q;
	logic [SPC_W-1:0] hit_q;
	logic [CPT_W-1:0] done_q;

	// Divider.
	logic [DVD_W-1:0]     dq_q;
	logic [SPC_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Packet sequencing.
	logic [1:0]      hdr_idx_q;
	logic [CH_W-1:0] lv_addr_q;
	logic [LW-1:0]   lv_left_q;

	// Level memory with per-entry valid flags.
	logic [LVL_W-1:0]        lvl_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] lvl_vld_q;
	logic [LVL_W-1:0]        rd_data_q;
	logic                    rd_vld_q;

	// Output register.
	logic              out_valid_q;
	logic              out_kind_q;
	logic [CH_W-1:0]   out_channel_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic [SPC_W-1:0] spc_eff;
	logic [CPT_W-1:0] cpt_eff;
	logic             accept;
	logic [SPC_W-1:0] hit_new;
	logic [SPC_W-1:0] sample_new;
	logic             visit_end;
	logic [DVD_W-1:0] dividend;
	logic [SPC_W:0]   rem_sh;
	logic             div_ge;
	logic [SPC_W:0]   rem_diff;
	logic [LVL_W-1:0] level_old;
	logic [LVL_W-1:0] raw_pct;
	logic [LVL_W+1:0] level_sum;
	logic [LVL_W-1:0] level_new;
	logic [CH_W-1:0]  cursor_next;
	logic [CH_W-1:0]  lv_addr_next;
	logic [CPT_W-1:0] done_new;
	logic             tick_end;
	logic             rd_en;
	logic [CH_W-1:0]  rd_addr;
	logic             out_free;
	logic             out_load;
	logic [BYTE_W-1:0] hdr_byte;

	// Effective settings: a zero sample count acts as one, and the channel
	// count is kept between one and the largest packet chunk.
	assign spc_eff = (spc_q == '0) ? SPC_W'(1) : spc_q;

	always_comb begin
		if (cpt_cfg_q == '0) begin
			cpt_eff = CPT_W'(1);
		end else if (cpt_cfg_q > CPT_W'(MAX_CHUNK)) begin
			cpt_eff = CPT_W'(MAX_CHUNK);
		end else begin
			cpt_eff = cpt_cfg_q;
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign hit_new    = hit_q + SPC_W'(detect);
	assign sample_new = sample_q + SPC_W'(1);
	assign visit_end  = (sample_new >= spc_eff);
	assign dividend   = DVD_W'(hit_new) * PERCENT;

	// One restoring division step per cycle; the quotient shifts into the
	// dividend register as the dividend bits shift out.
	assign rem_sh   = {rem_q, dq_q[DVD_W-1]};
	assign div_ge   = (rem_sh >= {1'b0, spc_eff});
	assign rem_diff = rem_sh - {1'b0, spc_eff};

	// Smoothing: (old * 3 + raw) / 4, with the raw percentage capped at 100.
	assign level_old = rd_vld_q ? rd_data_q : '0;
	assign raw_pct   = (dq_q > PERCENT) ? LVL_W'(PERCENT) : dq_q[LVL_W-1:0];
	assign level_sum = {2'b00, level_old} + {1'b0, level_old, 1'b0} + {2'b00, raw_pct};
	assign level_new = level_sum[LVL_W+1:2];

	assign cursor_next  = (cursor_q == CH_W'(NUM_CHANNELS - 1)) ? '0 : cursor_q + CH_W'(1);
	assign lv_addr_next = (lv_addr_q == CH_W'(NUM_CHANNELS - 1)) ? '0 : lv_addr_q + CH_W'(1);
	assign done_new     = done_q + CPT_W'(1);
	assign tick_end     = (done_new >= cpt_eff);

	// The memory is read only when its data is needed, so the old level
	// stays in the read register while the divider runs.
	assign rd_en   = accept || (state_q == S_RD);
	assign rd_addr = (state_q == S_RD) ? lv_addr_q : cursor_q;

	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free &&
		((state_q == S_HDR) || (state_q == S_LV) || (state_q == S_TUNE));

	always_comb begin
		case (hdr_idx_q)
			HDR_VERSION: hdr_byte = PKT_VERSION;
			HDR_CURSOR:  hdr_byte = {1'b0, cursor_q};
			HDR_START:   hdr_byte = {1'b0, tick_start_q};
			HDR_COUNT:   hdr_byte = {2'b00, cpt_eff};
			default:     hdr_byte = PKT_VERSION;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q     <= SPC_W'(1);
			cpt_cfg_q <= CPT_W'(8);
			stream_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SPC:    spc_q     <= cfg_data;
				REG_CPT:    cpt_cfg_q <= cfg_data[CPT_W-1:0];
				REG_STREAM: stream_q  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cursor_q     <= '0;
			tick_start_q <= '0;
			sample_q     <= '0;
			hit_q        <= '0;
			done_q       <= '0;
			div_cnt_q    <= '0;
			hdr_idx_q    <= '0;
			lv_left_q    <= '0;
			lv_addr_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((done_q == '0) && (sample_q == '0)) begin
							tick_start_q <= cursor_q;
						end
						if (visit_end) begin
							sample_q  <= '0;
							hit_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end else begin
							sample_q <= sample_new;
							hit_q    <= hit_new;
							state_q  <= S_TUNE;
						end
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					cursor_q <= cursor_next;
					if (tick_end) begin
						done_q <= '0;
						if (stream_q) begin
							hdr_idx_q <= HDR_VERSION;
							lv_addr_q <= tick_start_q;
							lv_left_q <= LW'(cpt_eff);
							state_q   <= S_HDR;
						end else begin
							state_q <= S_TUNE;
						end
					end else begin
						done_q  <= done_new;
						state_q <= S_TUNE;
					end
				end
				S_HDR: begin
					if (out_free) begin
						hdr_idx_q <= hdr_idx_q + 2'd1;
						if (hdr_idx_q == HDR_COUNT) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_LV;
				end
				S_LV: begin
					if (out_free) begin
						lv_addr_q <= lv_addr_next;
						lv_left_q <= lv_left_q - LW'(1);
						state_q   <= (lv_left_q == LW'(1)) ? S_TUNE : S_RD;
					end
				end
				S_TUNE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			dq_q  <= {dq_q[DVD_W-2:0], div_ge};
			rem_q <= div_ge ? rem_diff[SPC_W-1:0] : rem_sh[SPC_W-1:0];
		end
	end

	// Level memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			lvl_mem[cursor_q[AW-1:0]] <= level_new;
		end
		if (rd_en) begin
			rd_data_q <= lvl_mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (state_q == S_UPD) begin
				lvl_vld_q[cursor_q[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= lvl_vld_q[rd_addr[AW-1:0]];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			case (state_q)
				S_HDR: begin
					out_kind_q    <= KIND_PKT;
					out_channel_q <= '0;
					out_byte_q    <= hdr_byte;
					out_last_q    <= 1'b0;
				end
				S_LV: begin
					out_kind_q    <= KIND_PKT;
					out_channel_q <= '0;
					out_byte_q    <= {1'b0, level_old};
					out_last_q    <= 1'b0;
				end
				default: begin
					out_kind_q    <= KIND_TUNE;
					out_channel_q <= cursor_q;
					out_byte_q    <= '0;
					out_last_q    <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign channel   = out_channel_q;
	assign data_byte = out_byte_q;
	assign last_item = out_last_q;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < CH_W'(NUM_CHANNELS))
		else $error("cursor outside the channel range");

	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q <= sample_q)
		else $error("hit count exceeds sample count");

	a_level_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LV) |-> ($past(state_q) == S_RD || $past(state_q) == S_LV))
		else $error("level byte sent without a memory read");

	a_tune_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_TUNE)) |-> out_last_q)
		else $error("tune result not marked last");

	a_div_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> ($past(state_q) == S_DIV))
		else $error("level update without a finished division");
`endif

endmodule

// ===== tb/csla_level_checker.sv =====
// Result checker for the carrier scan level averager: mirrors the configuration
// writes, predicts the results of every accepted sample and compares them.
// Depends on csla_pkg.
`timescale 1ns / 1ps

module csla_level_checker
	import csla_pkg::*;
#(
	parameter int NUM_CHANNELS = 126,
	parameter int MAX_CHUNK    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CDATA_W-1:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               detect,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               kind,
	input  logic [CH_W-1:0]    channel,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               last_item,
	output int                 fail_count,
	output int                 outstanding
);

	localparam int FULL_SCALE = 100;

	typedef struct packed {
		logic              kind;
		logic [CH_W-1:0]   channel;
		logic [BYTE_W-1:0] data_byte;
		logic              last_item;
	} scan_result_t;

	scan_result_t expected_results[$];
	scan_result_t oldest;

	logic [LVL_W-1:0] levels [NUM_CHANNELS];
	logic [CH_W-1:0]  cursor;
	logic [CH_W-1:0]  tick_start;
	logic [SPC_W-1:0] samples_taken;
	logic [SPC_W-1:0] hits;
	logic [CPT_W-1:0] visits_done;

	logic [SPC_W-1:0] spc_setting;
	logic [CPT_W-1:0] cpt_setting;
	logic             stream_setting;

	task automatic push_result(input logic k, input logic [CH_W-1:0] ch,
			input logic [BYTE_W-1:0] b, input logic last);
		scan_result_t r;
		r.kind      = k;
		r.channel   = ch;
		r.data_byte = b;
		r.last_item = last;
		expected_results.push_back(r);
	endtask

	// Advances the scan state by one sample and queues what it should produce.
	task automatic predict_sample(input logic hit);
		int spc;
		int cpt;
		int raw;
		int idx;
		int i;
		spc = (spc_setting == 0) ? 1 : int'(spc_setting);
		cpt = (cpt_setting == 0) ? 1 : int'(cpt_setting);
		if (cpt > MAX_CHUNK) cpt = MAX_CHUNK;

		if (visits_done == 0 && samples_taken == 0) tick_start = cursor;
		if (hit) hits = hits + 1'b1;
		samples_taken = samples_taken + 1'b1;

		if (int'(samples_taken) >= spc) begin
			idx = int'(cursor) % NUM_CHANNELS;
			raw = int'(hits) * FULL_SCALE / spc;
			if (raw > FULL_SCALE) raw = FULL_SCALE;
			levels[idx] = LVL_W'((int'(levels[idx]) * 3 + raw) / 4);
			cursor = CH_W'((idx + 1) % NUM_CHANNELS);
			samples_taken = '0;
			hits = '0;
			visits_done = visits_done + 1'b1;

			if (int'(visits_done) >= cpt) begin
				if (stream_setting) begin
					push_result(KIND_PKT, '0, PKT_VERSION, 1'b0);
					push_result(KIND_PKT, '0, BYTE_W'(cursor), 1'b0);
					push_result(KIND_PKT, '0, BYTE_W'(tick_start), 1'b0);
					push_result(KIND_PKT, '0, BYTE_W'(cpt), 1'b0);
					for (i = 0; i < cpt; i++) begin
						push_result(KIND_PKT, '0,
							BYTE_W'(levels[(int'(tick_start) + i) % NUM_CHANNELS]), 1'b0);
					end
				end
				visits_done = '0;
			end
		end

		push_result(KIND_TUNE, cursor, '0, 1'b1);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (levels[i]) levels[i] = '0;
			cursor         = '0;
			tick_start     = '0;
			samples_taken  = '0;
			hits           = '0;
			visits_done    = '0;
			spc_setting    = 8'd1;
			cpt_setting    = 6'd8;
			stream_setting = 1'b0;
			expected_results.delete();
			fail_count     = 0;
			outstanding    = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SPC:    spc_setting = cfg_data[SPC_W-1:0];
					REG_CPT:    cpt_setting = cfg_data[CPT_W-1:0];
					REG_STREAM: stream_setting = cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) predict_sample(detect);

			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d channel %0d data_byte %0d last_item %0d",
						kind, channel, data_byte, last_item);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("kind", oldest.kind, kind);
					check_field("channel", oldest.channel, channel);
					check_field("data_byte", oldest.data_byte, data_byte);
					check_field("last_item", oldest.last_item, last_item);
				end
			end

			outstanding = expected_results.size();
		end
	end

endmodule

// ===== tb/carrier_scan_level_averager_tb.sv =====
// Testbench top for the carrier scan level averager: clock, reset, stimulus and verdict.
// Depends on csla_pkg, carrier_scan_level_averager and csla_level_checker.
`timescale 1ns / 1ps

module carrier_scan_level_averager_tb;
	import csla_pkg::*;

	// Longest stretch without any accepted request or result before the run is
	// declared hung. The slowest correct gap is the deliberate receiver hold-off
	// plus a full-length packet and some random stalls, and the quiet tail at the
	// end lasts TAIL_CYCLES, so this leaves a wide margin.
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 100;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 36;
	localparam int CALM_PHASE   = 3;
	localparam int SQUEEZE_PHASE = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CDATA_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               detect = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               kind;
	logic [CH_W-1:0]    channel;
	logic [BYTE_W-1:0]  data_byte;
	logic               last_item;

	int fail_count;
	int outstanding;

	// Random gaps on both sides are switched off for one whole phase so that
	// the block also sees long back-to-back runs.
	logic jitter_on = 1'b1;
	// Asks the receiver for one long hold-off; the receiver counts it itself.
	logic hold_request = 1'b0;
	int   hold_left = 0;
	bit   hold_served = 1'b0;
	int   quiet_cycles = 0;

	carrier_scan_level_averager DUT (.*);

	csla_level_checker level_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver side. Outside the hold-off it either takes every result or
	// refuses about one cycle in six, at random.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request && !hold_served) begin
			hold_served = 1'b1;
			hold_left   = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (!jitter_on) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 16);
		end
	end

	// Watchdog: a cycle in which neither a request nor a result moves counts
	// towards the limit, any handshake starts the count again.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** carrier_scan_level_averager: FAILED **");
			$finish;
		end
	end

	// Offers one sample and returns at the edge where it is accepted. The valid
	// line is only lowered when a gap is wanted, so back-to-back requests keep
	// it high across the handshake.
	task automatic send_sample(input logic hit);
		int gap;
		gap = 0;
		if (jitter_on) begin
			while ($urandom_range(0, 99) < 16) gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		detect   <= hit;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_bits(input logic [7:0] bits, input int count);
		int i;
		for (i = 0; i < count; i++) send_sample(bits[i]);
	endtask

	// Withdraws the request line and waits until every predicted result has
	// been seen. Every sample ends in a tune result, so once the last one is
	// out the block is idle. Sampling at the falling edge keeps the count
	// clear of the checker's own update at the rising edge.
	task automatic drain;
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [CDATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Registers are only rewritten with the block idle; the scan position and
	// partial counts carry over, which is how mid-visit and mid-tick lowering
	// is exercised.
	task automatic set_config(input logic [7:0] spc, input logic [7:0] cpt,
			input logic [7:0] stream);
		drain();
		write_reg(REG_SPC, spc);
		write_reg(REG_CPT, cpt);
		write_reg(REG_STREAM, stream);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int phase;
		int n;
		int hit_pct;
		int pick;
		logic [7:0] spc;
		logic [7:0] cpt;
		logic [7:0] stream;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero samples and zero channels per tick both behave as one, so every
		// sample ends a tick and a five-byte packet follows.
		set_config(8'd0, 8'd0, 8'd1);
		send_bits(8'b0000_1101, 4);

		// Largest sample count: six hits leave the visit open. All ones on the
		// data bus also checks that only bit 0 reaches the stream flag.
		set_config(8'd255, 8'd2, 8'hFF);
		send_bits(8'b0011_1111, 6);

		// Lowering the sample count mid-visit: seven hits over two samples is
		// well above full scale and must saturate at 100 per cent.
		set_config(8'd2, 8'd2, 8'd1);
		send_bits(8'b0000_0011, 3);

		// A tick size above the maximum saturates to 32; streaming is off.
		set_config(8'd1, 8'hFF, 8'd0);
		send_bits(8'b0001_0101, 5);

		// Lowering the tick size mid-tick ends the tick on the next visit.
		set_config(8'd1, 8'd1, 8'd1);
		send_bits(8'b0000_0010, 2);

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) spc = 8'd0;
			else if (pick == 1) spc = 8'd255;
			else if (pick == 2) spc = 8'($urandom_range(0, 255));
			else spc = 8'($urandom_range(1, 4));

			pick = $urandom_range(0, 9);
			if (pick == 0) cpt = 8'd0;
			else if (pick == 1) cpt = 8'd32;
			else if (pick == 2) cpt = 8'($urandom_range(0, 255));
			else cpt = 8'($urandom_range(1, 40));

			stream = {7'($urandom_range(0, 127)), ($urandom_range(0, 3) != 0)};

			// The pressure phase streams full-size packets so that the
			// output side backs up while samples keep being offered.
			if (phase == SQUEEZE_PHASE) begin
				spc    = 8'd1;
				cpt    = 8'd32;
				stream = 8'd1;
			end

			set_config(spc, cpt, stream);
			jitter_on    <= (phase != CALM_PHASE);
			hold_request <= (phase == SQUEEZE_PHASE);

			pick = $urandom_range(0, 3);
			if (pick == 0) hit_pct = 0;
			else if (pick == 1) hit_pct = 100;
			else hit_pct = $urandom_range(0, 100);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_sample($urandom_range(0, 99) < hit_pct);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("** carrier_scan_level_averager: PASSED **");
		end else begin
			$display("** carrier_scan_level_averager: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/csla_pkg.sv
rtl/carrier_scan_level_averager.sv
tb/csla_level_checker.sv
tb/carrier_scan_level_averager_tb.sv
